// File: rtl/core/rfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_pkg
// Types and constants shared by the frame deframer files.
// ----------------------------------------------------------------------------
package rfd_pkg;

  localparam logic [7:0]  HdrFirst     = 8'h52;
  localparam logic [7:0]  HdrSecond    = 8'h46;
  localparam logic [15:0] ResetMaxLen  = 16'd512;

  typedef enum logic [9:0] {
    PH_HUNT1   = 10'b00_0000_0001,
    PH_HUNT2   = 10'b00_0000_0010,
    PH_TYPE    = 10'b00_0000_0100,
    PH_ADDR_HI = 10'b00_0000_1000,
    PH_ADDR_LO = 10'b00_0001_0000,
    PH_CODE    = 10'b00_0010_0000,
    PH_LEN_HI  = 10'b00_0100_0000,
    PH_LEN_LO  = 10'b00_1000_0000,
    PH_PAYLOAD = 10'b01_0000_0000,
    PH_CSUM    = 10'b10_0000_0000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BADSUM  = 2'd2,
    KIND_TOOLONG = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       result_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  frame_type;
    logic [15:0] frame_address;
    logic [7:0]  frame_code;
    logic [15:0] frame_param_length;
  } result_t;

endpackage

// File: rtl/core/rfd_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd interfaces
// Valid/ready channels for received bytes, results and configuration.
// ----------------------------------------------------------------------------
interface rfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface rfd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  payload_byte;
  logic [7:0]  frame_type;
  logic [15:0] frame_address;
  logic [7:0]  frame_code;
  logic [15:0] frame_param_length;

  modport source (output valid, output result_kind, output payload_byte,
                  output frame_type, output frame_address, output frame_code,
                  output frame_param_length, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input frame_type, input frame_address, input frame_code,
                  input frame_param_length, output ready);
endinterface

interface rfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_param_length;

  modport source (output valid, output max_param_length, input ready);
  modport sink   (input valid, input max_param_length, output ready);
endinterface

// File: rtl/core/rfd_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_in_stage
// Input register for received bytes; takes a new byte every cycle that it
// holds none or the parser drains the held one.
// ----------------------------------------------------------------------------
module rfd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       take_i,
  output logic       held_valid_o,
  output logic [7:0] held_byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       load;

  assign in_ready_o   = !valid_q || take_i;
  assign load         = in_valid_i && in_ready_o;
  assign held_valid_o = valid_q;
  assign held_byte_o  = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
    end
  end

endmodule

// File: rtl/core/rfd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_parser
// Frame state machine: header hunt, field capture, length-limit check,
// payload count and checksum check, one byte per step.
// ----------------------------------------------------------------------------
module rfd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [7:0]       byte_i,
  input  logic [15:0]      max_len_i,
  output logic             res_valid_o,
  output rfd_pkg::result_t res_o
);
  import rfd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  code_q, code_d;
  logic [15:0] len_q, len_d;
  logic [15:0] rem_q, rem_d;
  logic [7:0]  sum_next;
  logic [7:0]  expect_sum;

  assign sum_next   = 8'(sum_q + byte_i);
  assign expect_sum = 8'(8'd0 - sum_q);

  always_comb begin
    phase_d     = phase_q;
    sum_d       = sum_q;
    type_d      = type_q;
    addr_d      = addr_q;
    code_d      = code_q;
    len_d       = len_q;
    rem_d       = rem_q;
    res_valid_o = 1'b0;
    res_o.result_kind  = KIND_PAYLOAD;
    res_o.payload_byte = 8'd0;

    unique case (phase_q)
      PH_HUNT1: begin
        if (byte_i == HdrFirst) begin
          sum_d   = byte_i;
          phase_d = PH_HUNT2;
        end
      end
      PH_HUNT2: begin
        priority if (byte_i == HdrSecond) begin
          sum_d   = sum_next;
          phase_d = PH_TYPE;
        end else if (byte_i == HdrFirst) begin
          sum_d = byte_i;
        end else begin
          phase_d = PH_HUNT1;
        end
      end
      PH_TYPE: begin
        sum_d   = sum_next;
        type_d  = byte_i;
        phase_d = PH_ADDR_HI;
      end
      PH_ADDR_HI: begin
        sum_d   = sum_next;
        addr_d  = {byte_i, 8'd0};
        phase_d = PH_ADDR_LO;
      end
      PH_ADDR_LO: begin
        sum_d   = sum_next;
        addr_d  = {addr_q[15:8], byte_i};
        phase_d = PH_CODE;
      end
      PH_CODE: begin
        sum_d   = sum_next;
        code_d  = byte_i;
        phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        sum_d   = sum_next;
        len_d   = {byte_i, 8'd0};
        phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        sum_d = sum_next;
        len_d = {len_q[15:8], byte_i};
        if (len_d > max_len_i) begin
          // reject oversize frame right away
          res_valid_o       = 1'b1;
          res_o.result_kind = KIND_TOOLONG;
          phase_d           = PH_HUNT1;
        end else begin
          rem_d   = len_d;
          phase_d = (len_d == 16'd0) ? PH_CSUM : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_d = sum_next;
        rem_d = 16'(rem_q - 16'd1);
        if (rem_q == 16'd1) begin
          phase_d = PH_CSUM;
        end
        res_valid_o        = 1'b1;
        res_o.payload_byte = byte_i;
      end
      PH_CSUM: begin
        res_valid_o       = 1'b1;
        res_o.result_kind = (byte_i == expect_sum) ? KIND_GOOD : KIND_BADSUM;
        phase_d           = PH_HUNT1;
      end
      default: begin
        phase_d = PH_HUNT1;
      end
    endcase

    res_o.frame_type         = type_d;
    res_o.frame_address      = addr_d;
    res_o.frame_code         = code_d;
    res_o.frame_param_length = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT1;
      sum_q   <= 8'd0;
      type_q  <= 8'd0;
      addr_q  <= 16'd0;
      code_q  <= 8'd0;
      len_q   <= 16'd0;
      rem_q   <= 16'd0;
    end else if (take_i) begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      type_q  <= type_d;
      addr_q  <= addr_d;
      code_q  <= code_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
    end
  end

endmodule

// File: rtl/core/rfd_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_out_stage
// Result register; holds a finished result until the consumer takes it.
// ----------------------------------------------------------------------------
module rfd_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic             res_valid_i,
  input  rfd_pkg::result_t res_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rfd_pkg::result_t out_o
);
  import rfd_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_i) begin
      valid_q <= res_valid_i;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

// File: rtl/core/rfid_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfid_frame_deframer
// Header/length/checksum deframer for a received byte stream.
// ----------------------------------------------------------------------------
// The block takes one byte per clock while the result slot is free and
// gives at most one result per byte: a payload byte, a good-frame or
// bad-checksum verdict at the checksum byte, or a length-over-limit error
// as soon as the low length byte arrives. Each byte passes an input
// register, the parse logic and a result register. The sustained rate is
// one byte per cycle while the consumer takes results, set by the frame
// state machine, which updates once per byte. Write max_param_length
// only while idle.
module rfid_frame_deframer (
  input  logic  clk_i,
  input  logic  rst_ni,
  rfd_byte_if.sink     byte_i,
  rfd_cfg_if.sink      cfg_i,
  rfd_result_if.source result_o
);
  import rfd_pkg::*;

  logic [15:0] max_len_q;
  logic        held_valid;
  logic [7:0]  held_byte;
  logic        out_free;
  logic        advance;
  logic        res_valid;
  result_t     res;
  result_t     out_res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= ResetMaxLen;
    end else if (cfg_i.valid) begin
      max_len_q <= cfg_i.max_param_length;
    end
  end

  // advance the parser whenever a byte is held and the result slot is free
  assign advance = held_valid && out_free;

  rfd_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (byte_i.valid),
    .in_ready_o   (byte_i.ready),
    .in_byte_i    (byte_i.in_byte),
    .take_i       (advance),
    .held_valid_o (held_valid),
    .held_byte_o  (held_byte)
  );

  rfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (advance),
    .byte_i      (held_byte),
    .max_len_i   (max_len_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rfd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (advance),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_o       (out_res)
  );

  assign result_o.result_kind        = out_res.result_kind;
  assign result_o.payload_byte       = out_res.payload_byte;
  assign result_o.frame_type         = out_res.frame_type;
  assign result_o.frame_address      = out_res.frame_address;
  assign result_o.frame_code         = out_res.frame_code;
  assign result_o.frame_param_length = out_res.frame_param_length;

endmodule
